[rtl/fwc_pkg.sv]
// Shared types and codes for the ordered queue with removal by ID.
`timescale 1ns / 1ps

package fwc_pkg;

	localparam int ID_W   = 10;
	localparam int FILL_W = 5;

	// Request codes
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESP
	} fwc_state_t;

	// One stored entry
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            kind;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load;      // capture the accepted item
		logic    push;      // write item at tail, count up
		logic    start;     // set up a scan from the head
		logic    scan;      // one scan/compact step
		logic    finish;    // close the scan, settle count and result
		logic    set_res;   // set result code with zero entry
		status_t res_code;
		logic    out_load;  // move result into output register
	} fwc_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic scan_done;
	} fwc_stat_t;

endpackage

[rtl/fwc_ctrl.sv]
// Controller state machine for the ordered queue with removal by ID.
`timescale 1ns / 1ps

module fwc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  fwc_pkg::fwc_stat_t stat,
	output fwc_pkg::fwc_cmd_t  cmd
);

	fwc_pkg::fwc_state_t state_q, state_d;
	logic                out_valid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fwc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load | (out_valid_q & out_stall);
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_code = fwc_pkg::ST_DONE;
		unique case (state_q)
			fwc_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = fwc_pkg::S_EXEC;
				end
			end
			fwc_pkg::S_EXEC: begin
				state_d = fwc_pkg::S_RESP;
				unique case (stat.op)
					fwc_pkg::OP_PUSH: begin
						cmd.set_res = 1'b1;
						if (stat.full) begin
							cmd.res_code = fwc_pkg::ST_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					fwc_pkg::OP_POP, fwc_pkg::OP_CANCEL: begin
						if (stat.empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = fwc_pkg::ST_EMPTY;
						end else begin
							cmd.start = 1'b1;
							state_d   = fwc_pkg::S_SCAN;
						end
					end
					fwc_pkg::OP_NOP: begin
						cmd.set_res = 1'b1;
					end
					default: begin
						cmd.set_res = 1'b1;
					end
				endcase
			end
			fwc_pkg::S_SCAN: begin
				if (stat.scan_done) begin
					cmd.finish = 1'b1;
					state_d    = fwc_pkg::S_RESP;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			fwc_pkg::S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = fwc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fwc_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != fwc_pkg::S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == fwc_pkg::S_IDLE && !in_stall)
		else $error("item loaded outside idle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.out_load)
		else $error("output register overwritten while stalled");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && state_q == fwc_pkg::S_IDLE)
		else $error("loaded result not shown");
`endif

endmodule

[rtl/fwc_dpath.sv]
// Datapath for the ordered queue: entry memory, pointers, scan and result registers.
`timescale 1ns / 1ps

module fwc_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fwc_pkg::fwc_cmd_t           cmd,
	output fwc_pkg::fwc_stat_t          stat,
	input  logic [1:0]                  op,
	input  logic [fwc_pkg::ID_W-1:0]    entry_id,
	input  logic                        entry_kind,
	output logic [1:0]                  status,
	output logic [fwc_pkg::ID_W-1:0]    out_id,
	output logic                        out_kind,
	output logic [fwc_pkg::FILL_W-1:0]  fill_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Circular pointer steps
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	fwc_pkg::entry_t  slot_mem_q [DEPTH];

	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	fwc_pkg::op_t     op_q;
	logic [fwc_pkg::ID_W-1:0] id_q;
	logic             kind_q;

	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    rd_left_q;
	fwc_pkg::entry_t  rd_data_q;
	logic [AW-1:0]    cmp_ptr_q;
	logic             cmp_vld_q;
	logic             found_q;

	fwc_pkg::status_t res_status_q;
	logic [fwc_pkg::ID_W-1:0] res_id_q;
	logic             res_kind_q;

	logic [1:0]       status_q;
	logic [fwc_pkg::ID_W-1:0] out_id_q;
	logic             out_kind_q;
	logic [fwc_pkg::FILL_W-1:0] fill_count_q;

	logic [AW:0]      tail_sum;
	logic [AW-1:0]    tail_ptr;
	logic             rd_en;
	logic             match;
	logic             shift_wr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	fwc_pkg::entry_t  wr_data;

	// Tail slot = head + count, wrapped
	assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
	assign tail_ptr = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
	                                               : AW'(tail_sum);

	// Scan: read one entry a cycle, compare the one read last cycle
	assign rd_en    = cmd.scan && (rd_left_q != '0);
	assign match    = (op_q == fwc_pkg::OP_POP) || (rd_data_q.id == id_q);
	assign shift_wr = cmd.scan && cmp_vld_q && found_q;

	// Single write port: push at tail or move an entry one slot toward head
	always_comb begin
		wr_en   = cmd.push || shift_wr;
		wr_addr = tail_ptr;
		wr_data = '{id: id_q, kind: kind_q};
		if (shift_wr) begin
			wr_addr = ptr_dec(cmp_ptr_q);
			wr_data = rd_data_q;
		end
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem_q[rd_ptr_q];
		end
	end

	// Queue and scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			rd_left_q <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.start) begin
				rd_left_q <= (op_q == fwc_pkg::OP_POP) ? CW'(1) : count_q;
				cmp_vld_q <= 1'b0;
				found_q   <= 1'b0;
			end
			if (cmd.scan) begin
				cmp_vld_q <= rd_en;
				if (rd_en) begin
					rd_left_q <= rd_left_q - 1'b1;
				end
				if (cmp_vld_q && !found_q && match) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.finish && found_q) begin
				count_q <= count_q - 1'b1;
				if (op_q == fwc_pkg::OP_POP) begin
					head_q <= ptr_inc(head_q);
				end
			end
		end
	end

	// Item, scan pointers and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= fwc_pkg::op_t'(op);
			id_q   <= entry_id;
			kind_q <= entry_kind;
		end
		if (cmd.start) begin
			rd_ptr_q <= head_q;
		end
		if (rd_en) begin
			rd_ptr_q  <= ptr_inc(rd_ptr_q);
			cmp_ptr_q <= rd_ptr_q;
		end
		if (cmd.scan && cmp_vld_q && !found_q && match) begin
			res_id_q   <= rd_data_q.id;
			res_kind_q <= rd_data_q.kind;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_id_q     <= '0;
			res_kind_q   <= 1'b0;
		end
		if (cmd.finish) begin
			if (found_q) begin
				res_status_q <= fwc_pkg::ST_DONE;
			end else begin
				res_status_q <= fwc_pkg::ST_NOTFOUND;
				res_id_q     <= '0;
				res_kind_q   <= 1'b0;
			end
		end
		if (cmd.out_load) begin
			status_q     <= res_status_q;
			out_id_q     <= res_id_q;
			out_kind_q   <= res_kind_q;
			fill_count_q <= fwc_pkg::FILL_W'(count_q);
		end
	end

	// Status toward the controller
	assign stat.op        = op_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.scan_done = (rd_left_q == '0) && !cmp_vld_q;

	assign status     = status_q;
	assign out_id     = out_id_q;
	assign out_kind   = out_kind_q;
	assign fill_count = fill_count_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full ##1 count_q == CW'($past(count_q) + 1'b1))
		else $error("push did not add one entry");
	a_found_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && found_q) |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("removal did not drop one entry");
	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && !found_q) |=>
			res_status_q == fwc_pkg::ST_NOTFOUND && count_q == $past(count_q))
		else $error("missed cancel changed the queue");
`endif

endmodule

[rtl/fifo_with_cancel_by_id.sv]
// Top level of the ordered queue with push, pop and cancel by ID.
`timescale 1ns / 1ps

// Ordered queue of up to DEPTH entries (10-bit ID plus kind bit), kept in a
// circular entry memory with a head pointer and a fill count. Each accepted
// item gives exactly one result: status, the removed entry (zero otherwise)
// and the count held afterwards. Push, no-op and any rejected request go
// from the execute state straight to the result register; pop and cancel
// first scan: the single read port of the entry memory is walked once
// from the head (only the head for a pop), one entry a cycle, and each
// entry after the match is written back one slot toward the head in
// the same pass. A new item is taken as soon as the previous result sits in
// the output register, even while that result is still stalled.
module fifo_with_cancel_by_id #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic [fwc_pkg::ID_W-1:0]    entry_id,
	input  logic                        entry_kind,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [fwc_pkg::ID_W-1:0]    out_id,
	output logic                        out_kind,
	output logic [fwc_pkg::FILL_W-1:0]  fill_count
);

	fwc_pkg::fwc_cmd_t  cmd;
	fwc_pkg::fwc_stat_t stat;

	// Sequencer
	fwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, scan and result registers
	fwc_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.entry_id   (entry_id),
		.entry_kind (entry_kind),
		.status     (status),
		.out_id     (out_id),
		.out_kind   (out_kind),
		.fill_count (fill_count)
	);

endmodule

[verif/tb.sv]
// Testbench for the ordered queue with push, pop and cancel by ID.
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1125;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PAUSE_EVERY  = 250;

	// One result as the block reports it
	typedef struct packed {
		fwc_pkg::status_t                st;
		logic [fwc_pkg::ID_W-1:0]        id;
		logic                            kind;
		logic [fwc_pkg::FILL_W-1:0]      fill;
	} result_t;

	// One directed step; want is used only where fixed is set
	typedef struct packed {
		fwc_pkg::op_t             op;
		logic [fwc_pkg::ID_W-1:0] id;
		logic                     kind;
		logic                     fixed;
		result_t                  want;
	} step_t;

	localparam int N_STEPS = 25;
	localparam step_t SCRIPT [N_STEPS] = '{
		// empty queue, ignored op code
		'{fwc_pkg::OP_POP,    10'd0,    1'b0, 1'b1, '{fwc_pkg::ST_EMPTY, 10'd0, 1'b0, 5'd0}},
		'{fwc_pkg::OP_CANCEL, 10'd1023, 1'b1, 1'b1, '{fwc_pkg::ST_EMPTY, 10'd0, 1'b0, 5'd0}},
		'{fwc_pkg::OP_NOP,    10'd1023, 1'b1, 1'b1, '{fwc_pkg::ST_DONE,  10'd0, 1'b0, 5'd0}},
		// fill up, with a duplicate ID near the head
		'{fwc_pkg::OP_PUSH,   10'd1023, 1'b1, 1'b1, '{fwc_pkg::ST_DONE,  10'd0, 1'b0, 5'd1}},
		'{fwc_pkg::OP_PUSH,   10'd0,    1'b0, 1'b1, '{fwc_pkg::ST_DONE,  10'd0, 1'b0, 5'd2}},
		'{fwc_pkg::OP_PUSH,   10'd1023, 1'b0, 1'b1, '{fwc_pkg::ST_DONE,  10'd0, 1'b0, 5'd3}},
		'{fwc_pkg::OP_PUSH,   10'h001,  1'b1, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h002,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h004,  1'b1, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h008,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h010,  1'b1, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h020,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h040,  1'b1, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h080,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h100,  1'b1, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h200,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h155,  1'b1, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h2AA,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_PUSH,   10'h3FE,  1'b1, 1'b0, '0},
		// full queue rejects
		'{fwc_pkg::OP_PUSH,   10'd7,    1'b1, 1'b1, '{fwc_pkg::ST_FULL,  10'd0, 1'b0, 5'd16}},
		// duplicate: only the match nearest the head goes
		'{fwc_pkg::OP_CANCEL, 10'd1023, 1'b0, 1'b1,
			'{fwc_pkg::ST_DONE, 10'd1023, 1'b1, 5'd15}},
		// match at the tail, full scan
		'{fwc_pkg::OP_CANCEL, 10'h3FE,  1'b0, 1'b0, '0},
		'{fwc_pkg::OP_CANCEL, 10'd7,    1'b0, 1'b1,
			'{fwc_pkg::ST_NOTFOUND, 10'd0, 1'b0, 5'd14}},
		'{fwc_pkg::OP_POP,    10'd0,    1'b1, 1'b1, '{fwc_pkg::ST_DONE,  10'd0, 1'b0, 5'd13}},
		'{fwc_pkg::OP_POP,    10'd1023, 1'b0, 1'b1,
			'{fwc_pkg::ST_DONE, 10'd1023, 1'b0, 5'd12}}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	fwc_pkg::op_t               op;
	logic [fwc_pkg::ID_W-1:0]   entry_id;
	logic                       entry_kind;
	logic                       out_valid;
	logic                       out_stall;
	logic [1:0]                 status;
	logic [fwc_pkg::ID_W-1:0]   out_id;
	logic                       out_kind;
	logic [fwc_pkg::FILL_W-1:0] fill_count;

	fwc_pkg::entry_t line_q [$];       // entries held, head first
	result_t         due_results [$];  // results still owed by the block
	int              items_taken;
	int              fail_count;
	int              quiet_cycles;
	bit              calm;             // no idling on either side
	logic            fixed_now;
	result_t         fixed_want;

	fifo_with_cancel_by_id #(.DEPTH(DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.entry_id   (entry_id),
		.entry_kind (entry_kind),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_id     (out_id),
		.out_kind   (out_kind),
		.fill_count (fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one request to the queue copy and give the result it owes
	function automatic result_t apply_request(fwc_pkg::op_t o,
			logic [fwc_pkg::ID_W-1:0] id, logic kind);
		result_t r;
		int      hit;
		r   = '{fwc_pkg::ST_DONE, '0, 1'b0, '0};
		hit = -1;
		case (o)
			fwc_pkg::OP_PUSH: begin
				if (line_q.size() >= DEPTH)
					r.st = fwc_pkg::ST_FULL;
				else
					line_q.push_back({id, kind});
			end
			fwc_pkg::OP_POP: begin
				if (line_q.size() == 0) begin
					r.st = fwc_pkg::ST_EMPTY;
				end else begin
					r.id   = line_q[0].id;
					r.kind = line_q[0].kind;
					void'(line_q.pop_front());
				end
			end
			fwc_pkg::OP_CANCEL: begin
				if (line_q.size() == 0) begin
					r.st = fwc_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < line_q.size() && hit < 0; i++)
						if (line_q[i].id == id)
							hit = i;
					if (hit < 0) begin
						r.st = fwc_pkg::ST_NOTFOUND;
					end else begin
						r.id   = line_q[hit].id;
						r.kind = line_q[hit].kind;
						line_q.delete(hit);
					end
				end
			end
			default: ;
		endcase
		r.fill = fwc_pkg::FILL_W'(line_q.size());
		return r;
	endfunction

	// Handshakes, prediction, result checks and watchdog
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result with nothing owed: status %0d, id %0d", status, out_id);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (out_id !== want.id) begin
						$error("out_id: expected %0d, got %0d", want.id, out_id);
						fail_count++;
					end
					if (out_kind !== want.kind) begin
						$error("out_kind: expected %0d, got %0d", want.kind, out_kind);
						fail_count++;
					end
					if (fill_count !== want.fill) begin
						$error("fill_count: expected %0d, got %0d", want.fill, fill_count);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_request(op, entry_id, entry_kind);
				if (fixed_now)
					want = fixed_want;
				due_results.push_back(want);
				items_taken++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Result side back-pressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = !calm && ($urandom_range(0, 99) < 9);
		end
	end

	// Offer one item, with random gaps before it; returns once it is taken
	task automatic send_item(fwc_pkg::op_t o, logic [fwc_pkg::ID_W-1:0] id, logic kind,
			logic fix, result_t want);
		int target;
		while (!calm && $urandom_range(0, 99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op         = o;
		entry_id   = id;
		entry_kind = kind;
		fixed_now  = fix;
		fixed_want = want;
		in_valid   = 1'b1;
		target     = items_taken + 1;
		do @(negedge clk); while (items_taken < target);
	endtask

	// Hold off new items until every owed result is back
	task automatic settle();
		in_valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	// Random request, biased to fill up or drain in turns of 60
	task automatic pick_request(input int n, output fwc_pkg::op_t o,
			output logic [fwc_pkg::ID_W-1:0] id, output logic kind);
		int roll;
		int push_pct;
		int pop_pct;
		push_pct = ((n / 60) % 2 == 0) ? 65 : 25;
		pop_pct  = ((n / 60) % 2 == 0) ? 15 : 35;
		roll     = $urandom_range(0, 99);
		if (roll < 3)
			o = fwc_pkg::OP_NOP;
		else if ($urandom_range(0, 99) < push_pct)
			o = fwc_pkg::OP_PUSH;
		else if ($urandom_range(0, 99 - push_pct) < pop_pct)
			o = fwc_pkg::OP_POP;
		else
			o = fwc_pkg::OP_CANCEL;
		// cancels mostly aim at a held ID; a small pool makes duplicates
		if (o == fwc_pkg::OP_CANCEL && line_q.size() > 0 && $urandom_range(0, 99) < 70)
			id = line_q[$urandom_range(0, line_q.size() - 1)].id;
		else if ($urandom_range(0, 99) < 40)
			id = fwc_pkg::ID_W'($urandom_range(0, 7));
		else
			id = fwc_pkg::ID_W'($urandom_range(0, 1023));
		kind = 1'($urandom_range(0, 1));
	endtask

	// Stimulus
	initial begin
		fwc_pkg::op_t             o;
		logic [fwc_pkg::ID_W-1:0] id;
		logic                     kind;
		int                       sent;
		int                       next_pause;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = fwc_pkg::OP_NOP;
		entry_id     = '0;
		entry_kind   = 1'b0;
		fixed_now    = 1'b0;
		fixed_want   = '0;
		calm         = 1'b0;
		items_taken  = 0;
		fail_count   = 0;
		quiet_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (SCRIPT[i])
			send_item(SCRIPT[i].op, SCRIPT[i].id, SCRIPT[i].kind, SCRIPT[i].fixed,
				SCRIPT[i].want);
		settle();

		sent       = 0;
		next_pause = PAUSE_EVERY;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= 400 && sent < 650);
			if (sent == next_pause) begin
				settle();
				next_pause += PAUSE_EVERY;
			end
			pick_request(sent, o, id, kind);
			send_item(o, id, kind, 1'b0, '0);
			if (o != fwc_pkg::OP_NOP)
				sent++;
		end
		calm = 1'b0;

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/fwc_pkg.sv
rtl/fwc_ctrl.sv
rtl/fwc_dpath.sv
rtl/fifo_with_cancel_by_id.sv
verif/tb.sv
